// ----- hw/rtl/three_key_press_classifier_assert.svh -----
// assertion macros used by the checker file
// no dependencies; pulled in with an include
`ifndef THREE_KEY_PRESS_CLASSIFIER_ASSERT_SVH
`define THREE_KEY_PRESS_CLASSIFIER_ASSERT_SVH

// same-cycle implication, masked during reset
`define TKPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define TKPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset too
`define TKPC_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tkpc_pkg.sv -----
// types and constants for the three-key press classifier
// no dependencies
`default_nettype none

package tkpc_pkg;

  localparam int NOW_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int EVENT_W   = 3;
  localparam int NUM_KEYS  = 3;

  localparam logic [CFG_DAT_W-1:0] DEBOUNCE_RST    = 16'd30;
  localparam logic [CFG_DAT_W-1:0] CENTER_LONG_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE    = 2'd0,
    REG_CENTER_LONG = 2'd1
  } tkpc_reg_t;

  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_PRESS   = 2'd1,
    EDGE_RELEASE = 2'd2
  } tkpc_edge_t;

  typedef enum logic [1:0] {
    OWN_NONE   = 2'd0,
    OWN_LEFT   = 2'd1,
    OWN_CENTER = 2'd2,
    OWN_RIGHT  = 2'd3
  } tkpc_owner_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE         = 3'd0,
    EV_LEFT_SHORT   = 3'd1,
    EV_CENTER_SHORT = 3'd2,
    EV_RIGHT_SHORT  = 3'd3,
    EV_CENTER_LONG  = 3'd4
  } tkpc_event_t;

  localparam int KEY_LEFT   = 0;
  localparam int KEY_CENTER = 1;
  localparam int KEY_RIGHT  = 2;

  // per-key status after this sample's debounce step
  typedef struct packed {
    tkpc_edge_t edge_kind;
    logic       was_settled;
    logic       stable;
    logic       up;
  } tkpc_key_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tkpc_in_if.sv -----
// input channel: one beat carries three raw key levels and a timestamp
// depends on tkpc_pkg
`default_nettype none

interface tkpc_in_if import tkpc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             left_pressed;
  logic             center_pressed;
  logic             right_pressed;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, left_pressed, center_pressed, right_pressed, now_ms,
                  input ready);
  modport sink   (input valid, left_pressed, center_pressed, right_pressed, now_ms,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tkpc_out_if.sv -----
// result channel: one beat carries one key event code
// depends on tkpc_pkg
`default_nettype none

interface tkpc_out_if import tkpc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] key_event;

  modport source (output valid, key_event, input ready);
  modport sink   (input valid, key_event, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tkpc_cfg_if.sv -----
// configuration write channel: register index and write data
// depends on tkpc_pkg
`default_nettype none

interface tkpc_cfg_if import tkpc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tkpc_debounce.sv -----
// debounce state and edge detection for one key
// depends on tkpc_pkg
`default_nettype none

module tkpc_debounce import tkpc_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 lvl,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [CFG_DAT_W-1:0] debounce_ms,
  output tkpc_key_stat_t            stat
);

  logic                 seen_r, seen_nxt;
  logic                 settled_r, settled_nxt;
  logic                 raw_r, raw_nxt;
  logic                 stable_r, stable_nxt;
  logic [TIME_BITS-1:0] chg_time_r, chg_time_nxt;
  logic [TIME_BITS-1:0] elapsed;
  tkpc_edge_t           edge_kind;

  always_comb begin
    seen_nxt     = 1'b1;
    settled_nxt  = settled_r;
    raw_nxt      = lvl;
    stable_nxt   = stable_r;
    chg_time_nxt = chg_time_r;
    edge_kind    = EDGE_NONE;
    if (!seen_r || (lvl != raw_r)) begin
      chg_time_nxt = now;
    end
    elapsed = now - chg_time_nxt;
    // first sample only seeds the raw level
    if (seen_r && (elapsed >= TIME_BITS'(debounce_ms))) begin
      if (!settled_r) begin
        settled_nxt = 1'b1;
        stable_nxt  = raw_nxt;
        edge_kind   = raw_nxt ? EDGE_PRESS : EDGE_NONE;
      end else if (stable_r != raw_nxt) begin
        stable_nxt = raw_nxt;
        edge_kind  = raw_nxt ? EDGE_PRESS : EDGE_RELEASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= 1'b0;
      settled_r <= 1'b0;
      raw_r     <= 1'b0;
      stable_r  <= 1'b0;
    end else if (en) begin
      seen_r    <= seen_nxt;
      settled_r <= settled_nxt;
      raw_r     <= raw_nxt;
      stable_r  <= stable_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chg_time_r <= chg_time_nxt;
    end
  end

  assign stat.edge_kind   = edge_kind;
  assign stat.was_settled = settled_r;
  assign stat.stable      = stable_nxt;
  assign stat.up          = settled_nxt && !raw_nxt && !stable_nxt;

endmodule

`default_nettype wire

// ----- hw/rtl/three_key_press_classifier.sv -----
// three-key press classifier: input register, debounce and owner logic, result register
// depends on tkpc_pkg, tkpc_in_if, tkpc_out_if, tkpc_cfg_if, tkpc_debounce
// path: a beat goes into the input register, then into the result register once out is not stalled
// throughput: one sample per cycle while out is not stalled; the owner/debounce update is a single pass per sample
// reset (synchronous, rst_n low): keys unseen, no owner, no wait, pipeline empty,
// debounce_ms = 30 and center_long_ms = 1000
`default_nettype none

module three_key_press_classifier import tkpc_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  tkpc_in_if.sink      in_ch,
  tkpc_out_if.source   out_ch,
  tkpc_cfg_if.sink     cfg_ch
);

  // configuration
  logic [CFG_DAT_W-1:0] debounce_r;
  logic [CFG_DAT_W-1:0] center_long_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r    <= DEBOUNCE_RST;
      center_long_r <= CENTER_LONG_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DEBOUNCE:    debounce_r    <= cfg_ch.data;
        REG_CENTER_LONG: center_long_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // input register
  logic                s1_valid_r;
  logic [NUM_KEYS-1:0] s1_lvl_r;
  logic [NOW_W-1:0]    s1_now_r;
  logic                s1_go;
  logic                out_valid_r;
  tkpc_event_t         out_event_r;

  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_lvl_r <= {in_ch.right_pressed, in_ch.center_pressed, in_ch.left_pressed};
      s1_now_r <= in_ch.now_ms;
    end
  end

  logic [TIME_BITS-1:0] now;
  assign now = TIME_BITS'(s1_now_r);

  // per-key debounce
  tkpc_key_stat_t stat [NUM_KEYS];

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    tkpc_debounce #(
      .TIME_BITS (TIME_BITS)
    ) u_deb (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (s1_go),
      .lvl         (s1_lvl_r[k]),
      .now         (now),
      .debounce_ms (debounce_r),
      .stat        (stat[k])
    );
  end

  // owner tracking
  tkpc_owner_t          owner_r, owner_nxt;
  logic                 boot_r, boot_nxt;
  logic                 long_r, long_nxt;
  logic                 wait_r, wait_nxt;
  logic [TIME_BITS-1:0] press_time_r, press_time_nxt;
  logic [TIME_BITS-1:0] held;
  logic                 all_up;
  tkpc_edge_t           owner_edge;
  tkpc_event_t          ev;

  assign all_up = stat[KEY_LEFT].up && stat[KEY_CENTER].up && stat[KEY_RIGHT].up;

  always_comb begin
    owner_nxt      = owner_r;
    boot_nxt       = boot_r;
    long_nxt       = long_r;
    wait_nxt       = wait_r;
    press_time_nxt = press_time_r;
    ev             = EV_NONE;
    owner_edge     = EDGE_NONE;
    held           = '0;
    if (wait_r) begin
      if (all_up) begin
        wait_nxt = 1'b0;
      end
    end else begin
      if (owner_r == OWN_NONE) begin
        if (stat[KEY_LEFT].edge_kind == EDGE_PRESS) begin
          owner_nxt      = OWN_LEFT;
          boot_nxt       = !stat[KEY_LEFT].was_settled;
          long_nxt       = 1'b0;
          press_time_nxt = now;
        end else if (stat[KEY_CENTER].edge_kind == EDGE_PRESS) begin
          owner_nxt      = OWN_CENTER;
          boot_nxt       = !stat[KEY_CENTER].was_settled;
          long_nxt       = 1'b0;
          press_time_nxt = now;
        end else if (stat[KEY_RIGHT].edge_kind == EDGE_PRESS) begin
          owner_nxt      = OWN_RIGHT;
          boot_nxt       = !stat[KEY_RIGHT].was_settled;
          long_nxt       = 1'b0;
          press_time_nxt = now;
        end
      end
      held = now - press_time_nxt;
      case (owner_nxt)
        OWN_LEFT:   owner_edge = stat[KEY_LEFT].edge_kind;
        OWN_CENTER: owner_edge = stat[KEY_CENTER].edge_kind;
        OWN_RIGHT:  owner_edge = stat[KEY_RIGHT].edge_kind;
        default:    owner_edge = EDGE_NONE;
      endcase
      if ((owner_nxt == OWN_CENTER) && stat[KEY_CENTER].stable && !long_nxt &&
          (held >= TIME_BITS'(center_long_r))) begin
        long_nxt = 1'b1;
        ev       = EV_CENTER_LONG;
      end else if (owner_edge == EDGE_RELEASE) begin
        // short event only for a fresh press that did not go long
        if (!boot_nxt && !long_nxt) begin
          case (owner_nxt)
            OWN_LEFT:   ev = EV_LEFT_SHORT;
            OWN_CENTER: ev = EV_CENTER_SHORT;
            OWN_RIGHT:  ev = EV_RIGHT_SHORT;
            default:    ev = EV_NONE;
          endcase
        end
        owner_nxt = OWN_NONE;
        boot_nxt  = 1'b0;
        long_nxt  = 1'b0;
        wait_nxt  = !all_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= OWN_NONE;
      boot_r  <= 1'b0;
      long_r  <= 1'b0;
      wait_r  <= 1'b0;
    end else if (s1_go) begin
      owner_r <= owner_nxt;
      boot_r  <= boot_nxt;
      long_r  <= long_nxt;
      wait_r  <= wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      press_time_r <= press_time_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_event_r <= ev;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.key_event = out_event_r;

endmodule

`default_nettype wire

// ----- hw/rtl/tkpc_checker.sv -----
// port-level checks for the three-key press classifier, bound to the top level
// depends on three_key_press_classifier_assert.svh and tkpc_pkg
`default_nettype none
`include "three_key_press_classifier_assert.svh"

module tkpc_checker import tkpc_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [EVENT_W-1:0] out_key_event
);

  // a held result beat stays until taken
  `TKPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out beat dropped")

  // a held result beat keeps its code
  `TKPC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_key_event), "out beat changed")

  // input only stalls when a finished result is stuck at the output
  `TKPC_ASSERT_NOW(a_in_stall, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled needlessly")

  // pipeline is empty right after reset
  `TKPC_ASSERT_ALWAYS_NEXT(a_rst_empty, clk, !rst_n, !out_valid, "out valid after reset")

endmodule

bind three_key_press_classifier tkpc_checker u_tkpc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_key_event (out_ch.key_event)
);

`default_nettype wire

// ----- test/tb_three_key_press_classifier.sv -----
`timescale 1ns / 100ps
// self-checking testbench for three_key_press_classifier: directed key gestures, then
// random press/hold/release sequences under several debounce and long-press settings
// depends on tkpc_pkg, tkpc_in_if, tkpc_out_if, tkpc_cfg_if and the classifier rtl

module tb_three_key_press_classifier;
  import tkpc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_PRINTS      = 40;
  localparam int SETTLE_CYCLES   = 8;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // tracks the classifier's state and the event codes it owes
  class key_event_board;
    logic [CFG_DAT_W-1:0] debounce_ms;
    logic [CFG_DAT_W-1:0] long_ms;
    bit                   seen[NUM_KEYS];
    bit                   settled[NUM_KEYS];
    bit                   raw[NUM_KEYS];
    bit                   stable[NUM_KEYS];
    logic [NOW_W-1:0]     change_t[NUM_KEYS];
    tkpc_owner_t          owner;
    bit                   boot_owned;
    bit                   long_done;
    bit                   lockout;
    logic [NOW_W-1:0]     press_t;
    tkpc_event_t          owed_q[$];
    int                   errors;

    function new();
      debounce_ms = DEBOUNCE_RST;
      long_ms     = CENTER_LONG_RST;
      for (int k = 0; k < NUM_KEYS; k++) begin
        seen[k]     = 1'b0;
        settled[k]  = 1'b0;
        raw[k]      = 1'b0;
        stable[k]   = 1'b0;
        change_t[k] = '0;
      end
      owner      = OWN_NONE;
      boot_owned = 1'b0;
      long_done  = 1'b0;
      lockout    = 1'b0;
      press_t    = '0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == REG_DEBOUNCE)
        debounce_ms = val;
      else if (idx == REG_CENTER_LONG)
        long_ms = val;
    endfunction

    function tkpc_edge_t settle_key(int k, bit lvl, logic [NOW_W-1:0] now);
      logic [NOW_W-1:0] held;
      if (!seen[k]) begin
        seen[k]     = 1'b1;
        raw[k]      = lvl;
        change_t[k] = now;
        return EDGE_NONE;
      end
      if (lvl != raw[k]) begin
        raw[k]      = lvl;
        change_t[k] = now;
      end
      held = now - change_t[k];
      if (held < NOW_W'(debounce_ms))
        return EDGE_NONE;
      if (!settled[k]) begin
        settled[k] = 1'b1;
        stable[k]  = raw[k];
        return stable[k] ? EDGE_PRESS : EDGE_NONE;
      end
      if (stable[k] == raw[k])
        return EDGE_NONE;
      stable[k] = raw[k];
      return stable[k] ? EDGE_PRESS : EDGE_RELEASE;
    endfunction

    function bit all_released();
      for (int k = 0; k < NUM_KEYS; k++)
        if (!settled[k] || raw[k] || stable[k])
          return 1'b0;
      return 1'b1;
    endfunction

    function void note_sample(logic [2:0] keys, logic [NOW_W-1:0] now);
      bit               was[NUM_KEYS];
      tkpc_edge_t       edg[NUM_KEYS];
      tkpc_event_t      ev;
      logic [NOW_W-1:0] held;
      int               oi;
      ev = EV_NONE;
      for (int k = 0; k < NUM_KEYS; k++)
        was[k] = settled[k];
      for (int k = 0; k < NUM_KEYS; k++)
        edg[k] = settle_key(k, keys[k], now);

      if (lockout) begin
        if (all_released())
          lockout = 1'b0;
        owed_q.push_back(EV_NONE);
        return;
      end

      // first pressed edge wins, left before center before right
      if (owner == OWN_NONE) begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (owner == OWN_NONE && edg[k] == EDGE_PRESS) begin
            owner      = tkpc_owner_t'(k + 1);
            boot_owned = !was[k];
            long_done  = 1'b0;
            press_t    = now;
          end
        end
      end

      held = now - press_t;
      if (owner == OWN_CENTER && stable[KEY_CENTER] && !long_done &&
          held >= NOW_W'(long_ms)) begin
        long_done = 1'b1;
        owed_q.push_back(EV_CENTER_LONG);
        return;
      end

      if (owner != OWN_NONE) begin
        oi = int'(owner) - 1;
        if (edg[oi] == EDGE_RELEASE) begin
          if (!boot_owned && !long_done)
            ev = tkpc_event_t'({1'b0, owner});
          owner      = OWN_NONE;
          boot_owned = 1'b0;
          long_done  = 1'b0;
          lockout    = !all_released();
        end
      end
      owed_q.push_back(ev);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("mismatch: %s", msg);
    endtask

    task check_result(logic [EVENT_W-1:0] got);
      tkpc_event_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("key_event beat %0d with nothing owed", got));
        return;
      end
      want = owed_q.pop_front();
      if (got !== want)
        report($sformatf("key_event got %0d owed %0d", got, want));
    endtask

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tkpc_in_if  in_if();
  tkpc_out_if out_if();
  tkpc_cfg_if cfg_if();

  three_key_press_classifier #(.TIME_BITS(32)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  key_event_board   board;
  bit               no_idle;
  bit               hold_req;
  int               deb;
  int               lng;
  int               step_max;
  int               sent_in_phase;
  logic [NOW_W-1:0] t_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // entered and left at a falling edge; valid stays high for the next call
  task automatic send_sample(input logic [2:0] keys, input logic [NOW_W-1:0] t);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.left_pressed   = keys[KEY_LEFT];
    in_if.center_pressed = keys[KEY_CENTER];
    in_if.right_pressed  = keys[KEY_RIGHT];
    in_if.now_ms         = t;
    in_if.valid          = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    board.note_sample(keys, t);
    @(negedge clk);
    sent_in_phase++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_if.index = idx;
    cfg_if.data  = val;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (board.owed() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // keep a key pattern until at least dur ms have passed since its first sample
  task automatic hold_keys(input logic [2:0] keys, input int dur);
    int elapsed;
    int step;
    elapsed = 0;
    send_sample(keys, t_now);
    while (elapsed < dur) begin
      step = $urandom_range(0, step_max);
      t_now += step;
      elapsed += step;
      send_sample(keys, t_now);
    end
  endtask

  // contact chatter shorter than the debounce window
  task automatic chatter(input logic [2:0] base, input logic [2:0] mask);
    repeat ($urandom_range(1, 3)) begin
      send_sample(base | mask, t_now);
      t_now += $urandom_range(0, deb / 3);
      send_sample(base, t_now);
      t_now += $urandom_range(0, deb / 3);
    end
  endtask

  task automatic play_gesture();
    int         kind;
    int         who;
    int         hold;
    logic [2:0] own_mask;
    logic [2:0] extra;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      hold_keys(3'b000, deb + $urandom_range(1, 2 * step_max));
      who = $urandom_range(0, NUM_KEYS - 1);
      own_mask = 3'b001 << who;
      extra = 3'b000;
      if ($urandom_range(0, 3) == 0)
        extra = 3'($urandom_range(1, 7)) & ~own_mask;
      if ($urandom_range(0, 1))
        chatter(3'b000, own_mask);
      if (who == KEY_CENTER)
        hold = deb + ($urandom_range(0, 1) ? lng + $urandom_range(0, step_max)
                                           : $urandom_range(0, lng));
      else
        hold = deb + $urandom_range(0, 3 * step_max);
      hold_keys(own_mask, hold);
      if (extra != 3'b000)
        hold_keys(own_mask | extra, deb + $urandom_range(0, step_max));
      if ($urandom_range(0, 1))
        chatter(extra, own_mask);
      hold_keys(extra, deb + $urandom_range(0, 2 * step_max));
      if (extra != 3'b000)
        hold_keys(3'b000, deb + $urandom_range(0, 2 * step_max));
    end else if (kind < 85) begin
      // random levels and time jumps, wrap included
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 4) == 0)
          t_now = $urandom;
        else
          t_now += $urandom_range(0, 2 * step_max + deb);
        send_sample(3'($urandom_range(0, 7)), t_now);
      end
    end else begin
      // short random taps, then a random key pattern held
      repeat ($urandom_range(1, 4)) begin
        send_sample(3'($urandom_range(1, 7)), t_now);
        t_now += $urandom_range(0, deb);
      end
      hold_keys(3'($urandom_range(0, 7)), $urandom_range(0, 2 * deb + step_max));
    end
  endtask

  task automatic run_phase(input int d, input int l, input int budget, input bit calm,
                           input bit squeeze);
    bit squeeze_left;
    squeeze_left = squeeze;
    if ($urandom_range(0, 1)) begin
      write_reg(REG_DEBOUNCE, CFG_DAT_W'(d));
      write_reg(REG_CENTER_LONG, CFG_DAT_W'(l));
    end else begin
      write_reg(REG_CENTER_LONG, CFG_DAT_W'(l));
      write_reg(REG_DEBOUNCE, CFG_DAT_W'(d));
    end
    deb = d;
    lng = l;
    step_max = (d > l ? d : l) / 3 + 3;
    no_idle = calm;
    t_now = $urandom;
    sent_in_phase = 0;
    while (sent_in_phase < budget) begin
      if (squeeze_left && sent_in_phase > budget / 3) begin
        hold_req = 1'b1;
        squeeze_left = 1'b0;
      end
      play_gesture();
    end
    drain();
  endtask

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_OFF_CYCLES - 1;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 20)
          stall = pick_gap();
      end
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        board.check_result(out_if.key_event);
      @(negedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    in_if.valid          = 1'b0;
    in_if.left_pressed   = 1'b0;
    in_if.center_pressed = 1'b0;
    in_if.right_pressed  = 1'b0;
    in_if.now_ms         = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_DEBOUNCE;
    cfg_if.data  = '0;
    no_idle  = 1'b0;
    hold_req = 1'b0;
    deb = int'(DEBOUNCE_RST);
    lng = int'(CENTER_LONG_RST);
    step_max = 16;
    sent_in_phase = 0;
    t_now = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // press held from start-up: no short event on release
    send_sample(3'b001, 32'd0);
    send_sample(3'b001, 32'd30);
    send_sample(3'b000, 32'd40);
    send_sample(3'b000, 32'd70);
    // center long, then a silent release
    send_sample(3'b010, 32'd100);
    send_sample(3'b010, 32'd130);
    send_sample(3'b010, 32'd1130);
    send_sample(3'b000, 32'd1140);
    send_sample(3'b000, 32'd1170);
    // all three at once: left wins, others still down lock out input
    send_sample(3'b111, 32'd2000);
    send_sample(3'b111, 32'd2030);
    send_sample(3'b110, 32'd2040);
    send_sample(3'b110, 32'd2070);
    send_sample(3'b111, 32'd2100);
    send_sample(3'b000, 32'd2200);
    send_sample(3'b000, 32'd2230);
    // right short
    send_sample(3'b100, 32'd2300);
    send_sample(3'b100, 32'd2330);
    send_sample(3'b000, 32'd2340);
    send_sample(3'b000, 32'd2370);
    // center short across the timestamp wrap
    send_sample(3'b010, 32'hFFFF_FFF0);
    send_sample(3'b010, 32'h0000_000E);
    send_sample(3'b000, 32'h0000_0020);
    send_sample(3'b000, 32'h0000_0040);
    drain();

    run_phase(0, 0, 105, 1'b1, 1'b0);
    run_phase(5, 100, 125, 1'b0, 1'b0);
    run_phase(65535, 65535, 95, 1'b0, 1'b0);
    write_reg(REG_SPARE_A, CFG_DAT_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DAT_W'($urandom));
    run_phase(30, 1000, 125, 1'b1, 1'b1);
    run_phase(20, 65535, 95, 1'b0, 1'b0);
    run_phase(65535, 0, 95, 1'b0, 1'b0);
    run_phase(1, 1, 105, 1'b0, 1'b0);
    run_phase($urandom_range(0, 200), $urandom_range(0, 3000), 90, 1'b0, 1'b0);

    if (board.owed() != 0)
      board.report($sformatf("%0d key events never arrived", board.owed()));
    if (board.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
